// ----- src/heatmap_false_color_mapper_core_macros.svh -----
// Assertion macros shared by the heatmap false-color mapper RTL.
`ifndef HEATMAP_FALSE_COLOR_MAPPER_CORE_MACROS_SVH
`define HEATMAP_FALSE_COLOR_MAPPER_CORE_MACROS_SVH

`ifndef SYNTHESIS
// Property must hold at every clock edge outside reset.
`define HFCM_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("hfcm: assertion failed");
// Condition must never be true outside reset.
`define HFCM_NEVER(lbl, clk, rstn, cond) \
  `HFCM_ASSERT(lbl, clk, rstn, !(cond))
`else
`define HFCM_ASSERT(lbl, clk, rstn, prop)
`define HFCM_NEVER(lbl, clk, rstn, cond)
`endif

`endif

// ----- src/hfcm_pkg.sv -----
// Shared constants, types and the color ramp function for the heatmap mapper.
package hfcm_pkg;

  // Default sample width (signed Q16.16)
  localparam int SAMPLE_BITS_DEF = 32;

  // Ramp index: 1024 entries, four segments of 256
  localparam int RAMP_BITS = 10;
  localparam int SEG_BITS  = 8;
  localparam int CNT_BITS  = $clog2(RAMP_BITS + 1);

  // Request kinds
  localparam logic [1:0] KIND_FIRST = 2'd0;
  localparam logic [1:0] KIND_MEAS  = 2'd1;
  localparam logic [1:0] KIND_MAP   = 2'd2;

  // Ramp segments
  localparam logic [1:0] SEG_BLUE_CYAN    = 2'd0;
  localparam logic [1:0] SEG_CYAN_GREEN   = 2'd1;
  localparam logic [1:0] SEG_GREEN_YELLOW = 2'd2;
  localparam logic [1:0] SEG_YELLOW_RED   = 2'd3;

  // Packed so that red lands in the low byte
  typedef struct packed {
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } rgb_t;

  // Blue -> cyan -> green -> yellow -> red
  function automatic rgb_t ramp_colour(input logic [RAMP_BITS-1:0] k);
    rgb_t c;
    logic [SEG_BITS-1:0] f;
    f = k[SEG_BITS-1:0];
    c = '0;
    unique case (k[RAMP_BITS-1:SEG_BITS])
      SEG_BLUE_CYAN: begin
        c.red = 8'd0; c.green = f; c.blue = 8'hff;
      end
      SEG_CYAN_GREEN: begin
        c.red = 8'd0; c.green = 8'hff; c.blue = ~f;
      end
      SEG_GREEN_YELLOW: begin
        c.red = f; c.green = 8'hff; c.blue = 8'd0;
      end
      SEG_YELLOW_RED: begin
        c.red = 8'hff; c.green = ~f; c.blue = 8'd0;
      end
      default: c = '0;
    endcase
    return c;
  endfunction

endpackage

// ----- src/hfcm_div.sv -----
// Restoring divider, one quotient bit per cycle, giving floor(2^10 * num / den).
module hfcm_div #(
  parameter int SAMPLE_BITS = hfcm_pkg::SAMPLE_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  input  logic [SAMPLE_BITS-1:0]          num,   // must be below den
  input  logic [SAMPLE_BITS-1:0]          den,
  output logic                            done,
  output logic [hfcm_pkg::RAMP_BITS-1:0]  quot
);

  logic [SAMPLE_BITS-1:0]                rem_r, rem_nxt;
  logic [SAMPLE_BITS-1:0]                den_r;
  logic [hfcm_pkg::RAMP_BITS-1:0]        quot_r, quot_nxt;
  logic [hfcm_pkg::CNT_BITS-1:0]         cnt_r, cnt_nxt;
  logic                                  busy_r, busy_nxt;
  logic                                  done_r, done_nxt;
  logic [SAMPLE_BITS:0]                  shifted;
  logic [SAMPLE_BITS:0]                  trial;
  logic                                  ge;

  // One restoring step
  always_comb begin
    shifted = {rem_r, 1'b0};
    ge      = (shifted >= {1'b0, den_r});
    trial   = shifted - {1'b0, den_r};
  end

  // Step control
  always_comb begin
    rem_nxt  = rem_r;
    quot_nxt = quot_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      rem_nxt  = num;
      quot_nxt = '0;
      cnt_nxt  = hfcm_pkg::CNT_BITS'(hfcm_pkg::RAMP_BITS);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rem_nxt  = ge ? trial[SAMPLE_BITS-1:0] : shifted[SAMPLE_BITS-1:0];
      quot_nxt = {quot_r[hfcm_pkg::RAMP_BITS-2:0], ge};
      cnt_nxt  = cnt_r - hfcm_pkg::CNT_BITS'(1);
      if (cnt_r == hfcm_pkg::CNT_BITS'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // Datapath, no reset
  always_ff @(posedge clk) begin
    rem_r  <= rem_nxt;
    quot_r <= quot_nxt;
    if (start) begin
      den_r <= den;
    end
  end

  assign done = done_r;
  assign quot = quot_r;

endmodule

// ----- src/hfcm_ramp.sv -----
// Ramp index to RGB lookup with the result output register.
module hfcm_ramp (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            ld,
  input  logic [hfcm_pkg::RAMP_BITS-1:0]  k,
  output logic                            free,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [23:0]                     out_tdata   // red, green, blue
);

  logic               valid_r, valid_nxt;
  hfcm_pkg::rgb_t     rgb_r;

  assign free = !valid_r || out_tready;

  // Valid flag: set on load, cleared when taken
  always_comb begin
    valid_nxt = valid_r;
    if (ld) begin
      valid_nxt = 1'b1;
    end else if (out_tready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Color register
  always_ff @(posedge clk) begin
    if (ld) begin
      rgb_r <= hfcm_pkg::ramp_colour(k);
    end
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = rgb_r;

endmodule

// ----- src/heatmap_false_color_mapper_core.sv -----
// Heatmap false-color mapper: frame min/max tracking, serial divider, color ramp.
// Measure requests (kind 0 and 1) are taken in the idle state and give no result.
// Map requests (kind 2) go through accept, setup, 10 divider steps, quotient handoff and
// output load; setup skips the divider when a compare alone settles the index. One request at a time.
// The result register lets the next request in while a color still waits.
// rst_n is synchronous active low: min resets to most positive, max to most negative.
`include "heatmap_false_color_mapper_core_macros.svh"

module heatmap_false_color_mapper_core #(
  parameter int SAMPLE_BITS = hfcm_pkg::SAMPLE_BITS_DEF,
  localparam int DATA_W     = ((SAMPLE_BITS + 7) / 8) * 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [DATA_W-1:0] in_tdata,    // sample
  input  logic [1:0]        in_tuser,    // kind
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [23:0]       out_tdata    // red, green, blue
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SETUP = 2'd1;
  localparam logic [1:0] ST_DIV   = 2'd2;
  localparam logic [1:0] ST_OUT   = 2'd3;

  logic [1:0]                      state_r, state_nxt;
  logic signed [SAMPLE_BITS-1:0]   min_r, min_nxt;
  logic signed [SAMPLE_BITS-1:0]   max_r, max_nxt;
  logic signed [SAMPLE_BITS-1:0]   v_r;
  logic [hfcm_pkg::RAMP_BITS-1:0]  k_r, k_nxt;
  logic signed [SAMPLE_BITS-1:0]   sample;
  logic                            acc;
  logic                            degen, below, above;
  logic [SAMPLE_BITS:0]            diff, span;
  logic                            div_start, div_done;
  logic [hfcm_pkg::RAMP_BITS-1:0]  div_quot;
  logic                            ramp_ld, ramp_free;

  assign sample    = in_tdata[SAMPLE_BITS-1:0];
  assign in_tready = (state_r == ST_IDLE);
  assign acc       = in_tvalid && in_tready;

  // Setup compares and differences
  always_comb begin
    degen = !(min_r < max_r);
    below = (v_r <= min_r);
    above = (v_r >= max_r);
    diff  = {v_r[SAMPLE_BITS-1], v_r} - {min_r[SAMPLE_BITS-1], min_r};
    span  = {max_r[SAMPLE_BITS-1], max_r} - {min_r[SAMPLE_BITS-1], min_r};
  end

  // Control sequencer
  always_comb begin
    state_nxt = state_r;
    min_nxt   = min_r;
    max_nxt   = max_r;
    k_nxt     = k_r;
    div_start = 1'b0;
    ramp_ld   = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (acc) begin
          case (in_tuser)
            hfcm_pkg::KIND_FIRST: begin
              min_nxt = sample;
              max_nxt = sample;
            end
            hfcm_pkg::KIND_MEAS: begin
              if (sample > max_r) max_nxt = sample;
              if (sample < min_r) min_nxt = sample;
            end
            hfcm_pkg::KIND_MAP: begin
              state_nxt = ST_SETUP;
            end
            default: ;
          endcase
        end
      end
      ST_SETUP: begin
        if (degen || below) begin
          k_nxt     = '0;
          state_nxt = ST_OUT;
        end else if (above) begin
          k_nxt     = '1;
          state_nxt = ST_OUT;
        end else begin
          div_start = 1'b1;
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          k_nxt     = div_quot;
          state_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        if (ramp_free) begin
          ramp_ld   = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      min_r   <= {1'b0, {(SAMPLE_BITS-1){1'b1}}};
      max_r   <= {1'b1, {(SAMPLE_BITS-1){1'b0}}};
    end else begin
      state_r <= state_nxt;
      min_r   <= min_nxt;
      max_r   <= max_nxt;
    end
  end

  // Sample and index, no reset
  always_ff @(posedge clk) begin
    if (acc) begin
      v_r <= sample;
    end
    k_r <= k_nxt;
  end

  hfcm_div #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (diff[SAMPLE_BITS-1:0]),
    .den   (span[SAMPLE_BITS-1:0]),
    .done  (div_done),
    .quot  (div_quot)
  );

  hfcm_ramp u_ramp (
    .clk        (clk),
    .rst_n      (rst_n),
    .ld         (ramp_ld),
    .k          (k_r),
    .free       (ramp_free),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  // After any measure request the frame range is ordered
  `HFCM_ASSERT(a_range_ordered, clk, rst_n, (acc && (in_tuser == hfcm_pkg::KIND_FIRST || in_tuser == hfcm_pkg::KIND_MEAS)) |=> (min_r <= max_r))
  // Divider finishes only while the sequencer waits for it
  `HFCM_NEVER(a_div_done_state, clk, rst_n, div_done && (state_r != ST_DIV))
  // A color is never loaded over one still waiting
  `HFCM_NEVER(a_no_overwrite, clk, rst_n, ramp_ld && out_tvalid && !out_tready)

endmodule

// ----- test/tb_heatmap_false_color_mapper_core.sv -----
// Self-checking testbench for the heatmap false-color mapper core.
module tb_heatmap_false_color_mapper_core;

  localparam int         RAMP_SIZE   = 1024;
  localparam int         SEG_STEPS   = 256;
  localparam int         ITEM_TARGET = 1050;
  localparam logic [1:0] KIND_NONE   = 2'd3;  // unused kind, dropped by the block

  typedef struct {
    logic [1:0]         kind;
    logic signed [31:0] sample;
  } sample_req_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata = '0;   // sample
  logic [1:0]  in_tuser = '0;   // kind
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;       // red, green, blue

  sample_req_t     pending[$];
  hfcm_pkg::rgb_t  colours_due[$];
  sample_req_t     cur_req;
  int              in_gap = 0;
  int              out_gap = 0;
  int              in_quiet = 0;
  int              out_quiet = 0;
  int              fail_count = 0;
  int              queued = 0;

  // Frame range as the block should hold it
  logic signed [31:0] track_min = 32'sh7fff_ffff;
  logic signed [31:0] track_max = 32'sh8000_0000;

  heatmap_false_color_mapper_core i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Expected color for a map request against the current frame range
  function automatic hfcm_pkg::rgb_t predict_colour(logic signed [31:0] v);
    longint         span;
    longint         offset;
    longint         k;
    hfcm_pkg::rgb_t c;
    span   = longint'(track_max) - longint'(track_min);
    offset = longint'(v) - longint'(track_min);
    if (span <= 0 || offset <= 0) begin
      k = 0;
    end else if (offset >= span) begin
      k = RAMP_SIZE - 1;
    end else begin
      k = (offset * RAMP_SIZE) / span;
      if (k > RAMP_SIZE - 1) k = RAMP_SIZE - 1;
    end
    if (k < SEG_STEPS) begin
      c.red = 8'd0; c.green = 8'(k); c.blue = 8'd255;
    end else if (k < 2 * SEG_STEPS) begin
      c.red = 8'd0; c.green = 8'd255; c.blue = 8'(2 * SEG_STEPS - 1 - k);
    end else if (k < 3 * SEG_STEPS) begin
      c.red = 8'(k - 2 * SEG_STEPS); c.green = 8'd255; c.blue = 8'd0;
    end else begin
      c.red = 8'd255; c.green = 8'(4 * SEG_STEPS - 1 - k); c.blue = 8'd0;
    end
    return c;
  endfunction

  // Idle length: mostly none, some short, few long; occasional quiet stretches
  function automatic int next_gap(inout int quiet);
    int r;
    if (quiet > 0) begin
      quiet--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 2) begin
      quiet = $urandom_range(30, 80);
      return 0;
    end
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic queue_item(input logic [1:0] kind, input logic [31:0] sample);
    sample_req_t r;
    r.kind   = kind;
    r.sample = sample;
    pending.push_back(r);
    if (kind != KIND_NONE) queued++;
  endtask

  // Sample drawn near a base value, spread over 2^s
  function automatic logic [31:0] near(logic [31:0] base, int s);
    logic [31:0] mask;
    mask = (s >= 32) ? 32'hffff_ffff : ((32'd1 << s) - 32'd1);
    return base + ($urandom() & mask);
  endfunction

  // Driver: presents pending requests and updates the prediction on accept
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      track_min = 32'sh7fff_ffff;
      track_max = 32'sh8000_0000;
    end else begin
      if (in_tvalid && in_tready) begin
        case (cur_req.kind)
          hfcm_pkg::KIND_FIRST: begin
            track_min = cur_req.sample;
            track_max = cur_req.sample;
          end
          hfcm_pkg::KIND_MEAS: begin
            if (cur_req.sample > track_max) track_max = cur_req.sample;
            if (cur_req.sample < track_min) track_min = cur_req.sample;
          end
          hfcm_pkg::KIND_MAP: colours_due.push_back(predict_colour(cur_req.sample));
          default: ;
        endcase
      end
      if (!in_tvalid || in_tready) begin
        if (in_gap > 0) begin
          in_gap--;
          in_tvalid <= 1'b0;
        end else if (pending.size() > 0) begin
          cur_req = pending.pop_front();
          in_tdata  <= cur_req.sample;
          in_tuser  <= cur_req.kind;
          in_tvalid <= 1'b1;
          in_gap = next_gap(in_quiet);
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor: random backpressure, compare each color with the oldest expected
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (colours_due.size() == 0) begin
          $display("%0t: unexpected color, actual %h", $time, out_tdata);
          fail_count++;
        end else begin
          hfcm_pkg::rgb_t want;
          hfcm_pkg::rgb_t got;
          want = colours_due.pop_front();
          got  = out_tdata;
          if (got.red !== want.red) begin
            $display("%0t: red expected %0d actual %0d", $time, want.red, got.red);
            fail_count++;
          end
          if (got.green !== want.green) begin
            $display("%0t: green expected %0d actual %0d", $time, want.green, got.green);
            fail_count++;
          end
          if (got.blue !== want.blue) begin
            $display("%0t: blue expected %0d actual %0d", $time, want.blue, got.blue);
            fail_count++;
          end
        end
      end
      if (out_gap > 0) begin
        out_gap--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
        out_gap = next_gap(out_quiet);
      end
    end
  end

  // Stimulus, reset and end of run
  initial begin
    logic signed [31:0] lo;
    logic signed [31:0] hi;
    logic [31:0]        base;
    logic [31:0]        v;
    int                 spread;
    int                 n;
    int                 r;

    // Map before any frame: max below min gives index 0
    queue_item(hfcm_pkg::KIND_MAP, 32'h0001_0000);
    queue_item(KIND_NONE, 32'hffff_ffff);
    // Measure with no frame start acts as a start
    queue_item(hfcm_pkg::KIND_MEAS, 32'h0000_0000);
    queue_item(hfcm_pkg::KIND_MEAS, 32'h0064_0000);
    queue_item(hfcm_pkg::KIND_MAP, 32'h0000_0000);   // at min
    queue_item(hfcm_pkg::KIND_MAP, 32'h0064_0000);   // at max, clamped
    queue_item(hfcm_pkg::KIND_MAP, 32'h0032_0000);   // midpoint
    queue_item(hfcm_pkg::KIND_MAP, 32'hffff_ffff);   // below min
    queue_item(hfcm_pkg::KIND_MAP, 32'h7fff_ffff);   // above max
    // Full signed range, at least one sample per segment
    queue_item(hfcm_pkg::KIND_FIRST, 32'h8000_0000);
    queue_item(hfcm_pkg::KIND_MEAS, 32'h7fff_ffff);
    queue_item(hfcm_pkg::KIND_MAP, 32'h8000_0000);
    queue_item(hfcm_pkg::KIND_MAP, 32'hc000_0000);
    queue_item(hfcm_pkg::KIND_MAP, 32'h0000_0000);
    queue_item(hfcm_pkg::KIND_MAP, 32'h4000_0000);
    queue_item(hfcm_pkg::KIND_MAP, 32'h7fff_ffff);
    // Flat frame: max equals min
    queue_item(hfcm_pkg::KIND_FIRST, 32'h0012_3456);
    queue_item(hfcm_pkg::KIND_MAP, 32'h0012_3456);
    queue_item(hfcm_pkg::KIND_MAP, 32'h7fff_ffff);
    // Ignored kind leaves the range alone
    queue_item(hfcm_pkg::KIND_FIRST, 32'hfff0_0000);
    queue_item(hfcm_pkg::KIND_MEAS, 32'h0010_0000);
    queue_item(KIND_NONE, 32'h0000_0000);
    queue_item(hfcm_pkg::KIND_MAP, 32'h0008_0000);

    // Random frames, with some noise and broken sequences
    while (queued < ITEM_TARGET) begin
      r = $urandom_range(0, 99);
      if (r < 85) begin
        spread = ($urandom_range(0, 3) == 0) ? 32 : $urandom_range(0, 31);
        base   = $urandom();
        v  = near(base, spread);
        lo = v;
        hi = v;
        queue_item(hfcm_pkg::KIND_FIRST, v);
        n = $urandom_range(0, 5);
        repeat (n) begin
          v = near(base, spread);
          if ($signed(v) < lo) lo = v;
          if ($signed(v) > hi) hi = v;
          queue_item(hfcm_pkg::KIND_MEAS, v);
        end
        n = $urandom_range(1, 8);
        repeat (n) begin
          r = $urandom_range(0, 99);
          if (r < 75)      v = near(base, spread);
          else if (r < 83) v = lo;
          else if (r < 91) v = hi;
          else             v = $urandom();
          if ($urandom_range(0, 19) == 0) queue_item(KIND_NONE, $urandom());
          queue_item(hfcm_pkg::KIND_MAP, v);
        end
      end else begin
        n = $urandom_range(1, 4);
        repeat (n) queue_item(2'($urandom_range(0, 3)), $urandom());
      end
    end

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    while (pending.size() != 0 || in_tvalid) @(posedge clk);
    while (colours_due.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);

    if (colours_due.size() != 0)
      $display("%0t: %0d expected colors never arrived", $time, colours_due.size());
    if (fail_count == 0 && colours_due.size() == 0) begin
      $display("heatmap_false_color_mapper_core verification clean");
    end else begin
      $display("heatmap_false_color_mapper_core verification failed");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #20_000_000;
    $display("heatmap_false_color_mapper_core verification failed");
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+src
src/hfcm_pkg.sv
src/hfcm_div.sv
src/hfcm_ramp.sv
src/heatmap_false_color_mapper_core.sv
test/tb_heatmap_false_color_mapper_core.sv
